FILE: rtl/core/sha256_pkg.sv
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load;
    logic step;
    logic accum;
    logic init;
  } rnd_ctrl_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMark = 8'h80;

  function automatic word_t big_sig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

FILE: rtl/core/sha256_sched.sv
module sha256_sched import sha256_pkg::*; (
  input  logic       clk_i,
  input  logic       byte_en_i,
  input  logic [7:0] byte_i,
  input  logic       step_i,
  output word_t      w_o
);

  // oldest word in the top slot
  logic [15:0][31:0] win_q, win_d;
  word_t             next_w;

  assign next_w = small_sig1(win_q[1]) + win_q[6] + small_sig0(win_q[14]) + win_q[15];
  assign w_o    = win_q[15];

  always_comb begin
    win_d = win_q;
    if (byte_en_i) begin
      win_d = 512'({win_q, byte_i});
    end else if (step_i) begin
      win_d = {win_q[14:0], next_w};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

FILE: rtl/core/sha256_round.sv
module sha256_round import sha256_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rnd_ctrl_t        ctrl_i,
  input  word_t            k_i,
  input  word_t            w_i,
  output logic [7:0][31:0] chain_o
);

  logic [7:0][31:0] chain_q;
  logic [7:0][31:0] v_q;
  logic [7:0][31:0] iv;
  word_t            ch, maj, t1, t2;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      iv[i] = InitH[i];
    end
  end

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sig1(v_q[4]) + ch + k_i + w_i;
  assign t2  = big_sig0(v_q[0]) + maj;

  assign chain_o = chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= iv;
    end else if (ctrl_i.init) begin
      chain_q <= iv;
    end else if (ctrl_i.accum) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= chain_q;
    end else if (ctrl_i.step) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

FILE: rtl/core/sha256_hash_stream.sv
// sha-256 over a byte stream, one round per cycle on a shared round unit
// a byte that does not fill the block is taken while ready stays high; a byte that fills it
// holds ready low through the compression (64 rounds, 1 chaining add)
// finish: the pad and length bytes plus the rounds and add of each compressed block, at most
// two blocks, then 8 digest items at one per cycle when taken at once
// async active-low reset loads the initial hash values and clears all counts
module sha256_hash_stream import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // data_byte
  input  logic        s_axis_tuser_i,  // has_byte
  input  logic        s_axis_tlast_i,  // finish
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast_o   // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_e;

  state_e           state_q, ret_q;
  phase_e           phase_q;
  logic [5:0]       fill_q;
  logic [5:0]       cnt_q;
  logic [2:0]       idx_q;
  logic [63:0]      len_q;
  logic             tvalid_q;

  logic             feed_en;
  logic [7:0]       feed_byte;
  logic [2:0]       len_sel;
  rnd_ctrl_t        ctrl;
  word_t            w_t;
  logic [7:0][31:0] chain;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = {5'd0, idx_q, chain[idx_q]};
  assign m_axis_tlast_o  = (idx_q == 3'd7);

  // length bytes go out most significant first
  assign len_sel = ~fill_q[2:0];

  always_comb begin
    feed_en    = 1'b0;
    feed_byte  = s_axis_tdata_i;
    ctrl       = '0;
    case (state_q)
      ST_IDLE: begin
        feed_en = s_axis_tvalid_i && s_axis_tuser_i;
      end
      ST_PAD: begin
        case (phase_q)
          PH_MARK: begin
            feed_en   = 1'b1;
            feed_byte = PadMark;
          end
          PH_ZERO: begin
            feed_en   = (fill_q != 6'd56);
            feed_byte = 8'd0;
          end
          PH_LEN: begin
            feed_en   = 1'b1;
            feed_byte = len_q[{len_sel, 3'b000} +: 8];
          end
          default: begin
            feed_en = 1'b0;
          end
        endcase
      end
      ST_COMP: begin
        ctrl.step = 1'b1;
      end
      ST_ADD: begin
        ctrl.accum = 1'b1;
      end
      ST_OUT: begin
        ctrl.init = m_axis_tready_i && (idx_q == 3'd7);
      end
      default: begin
        feed_en = 1'b0;
      end
    endcase
    ctrl.load = feed_en && (fill_q == 6'd63);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      phase_q  <= PH_MARK;
      fill_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      len_q    <= '0;
      tvalid_q <= 1'b0;
    end else begin
      if (feed_en) begin
        fill_q <= fill_q + 6'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            phase_q <= PH_MARK;
            if (s_axis_tuser_i) begin
              len_q <= len_q + 64'd8;
            end
            if (s_axis_tuser_i && fill_q == 6'd63) begin
              state_q <= ST_COMP;
              ret_q   <= s_axis_tlast_i ? ST_PAD : ST_IDLE;
            end else if (s_axis_tlast_i) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          case (phase_q)
            PH_MARK: begin
              phase_q <= PH_ZERO;
              if (fill_q == 6'd63) begin
                state_q <= ST_COMP;
                ret_q   <= ST_PAD;
              end
            end
            PH_ZERO: begin
              if (fill_q == 6'd56) begin
                phase_q <= PH_LEN;
              end else if (fill_q == 6'd63) begin
                state_q <= ST_COMP;
                ret_q   <= ST_PAD;
              end
            end
            PH_LEN: begin
              if (fill_q == 6'd63) begin
                state_q <= ST_COMP;
                ret_q   <= ST_OUT;
              end
            end
            default: begin
              phase_q <= PH_MARK;
            end
          endcase
        end
        ST_COMP: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          state_q <= ret_q;
          if (ret_q == ST_OUT) begin
            tvalid_q <= 1'b1;
            idx_q    <= '0;
          end
        end
        ST_OUT: begin
          if (m_axis_tready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              tvalid_q <= 1'b0;
              state_q  <= ST_IDLE;
              len_q    <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  sha256_sched u_sched (
    .clk_i     (clk_i),
    .byte_en_i (feed_en),
    .byte_i    (feed_byte),
    .step_i    (ctrl.step),
    .w_o       (w_t)
  );

  sha256_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .k_i     (RoundK[cnt_q]),
    .w_i     (w_t),
    .chain_o (chain)
  );

endmodule
